/* design/wrld_pkg.sv */
`default_nettype none

package wrld_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned PHASE_W  = 2;
    localparam int unsigned REPS_W   = 9;
    localparam int unsigned TOTAL_W  = 20;
    localparam int unsigned LIMIT_W  = 21;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned ADDR_W   = 4;
    localparam int unsigned DATA_W   = 32;
    localparam int unsigned OUT_W    = 40;

    localparam logic [TOTAL_W-1:0] TOTAL_SAT = '1;

    typedef enum logic [STATUS_W-1:0] {
        ST_RUN      = 2'd0,
        ST_END      = 2'd1,
        ST_OVERFLOW = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        REG_END_CODE    = 2'd0,
        REG_TOGGLE_CODE = 2'd1,
        REG_MAX_LENGTH  = 2'd2
    } t_reg_idx;

    localparam logic [BYTE_W-1:0]  END_CODE_RST    = 8'd255;
    localparam logic [BYTE_W-1:0]  TOGGLE_CODE_RST = 8'd252;
    localparam logic [LIMIT_W-1:0] MAX_LENGTH_RST  = 21'd1048576;

    typedef struct packed {
        logic [BYTE_W-1:0]  end_code;
        logic [BYTE_W-1:0]  toggle_code;
        logic [LIMIT_W-1:0] max_length;
    } t_cfg;

endpackage

`default_nettype wire

/* design/waveform_run_length_decoder.sv */
`default_nettype none

// Channel   Dir  Payload
// s_t*      in   tdata[7:0] byte_in; tuser start_of_stream
// m_t*      out  tuser status; tdata phases, repeat_count, total_values
// p*        in   APB registers: end_code @0x0, toggle_code @0x4, max_length @0x8
//
// One byte per cycle while no held result stalls the input register; m_tvalid follows
// the s_t* transfer through the input register, then the result register.
// Synchronous active-low reset clears modes, total and both valid flags.
// A held result stalls the input register only when m_tready is low.

module waveform_run_length_decoder (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              s_tvalid,
    output logic                             s_tready,
    input  wire  [7:0]                       s_tdata,  // [7:0] byte_in
    input  wire                              s_tuser,  // [0] start_of_stream
    output logic                             m_tvalid,
    input  wire                              m_tready,
    // [1:0] phase_0, [3:2] phase_1, [5:4] phase_2, [7:6] phase_3,
    // [16:8] repeat_count, [36:17] total_values, [39:37] zero
    output logic [wrld_pkg::OUT_W-1:0]       m_tdata,
    output logic [wrld_pkg::STATUS_W-1:0]    m_tuser,  // [1:0] status
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire  [wrld_pkg::ADDR_W-1:0]      paddr,
    input  wire  [wrld_pkg::DATA_W-1:0]      pwdata,
    output logic [wrld_pkg::DATA_W-1:0]      prdata,
    output logic                             pready
);

    wrld_pkg::t_cfg w_cfg;

    wrld_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // input register
    logic                         r_in_valid;
    logic [wrld_pkg::BYTE_W-1:0]  r_in_byte;
    logic                         r_in_sos;

    // decoder state
    logic                         r_literal;
    logic                         r_await;
    logic [wrld_pkg::BYTE_W-1:0]  r_held;
    logic [wrld_pkg::LIMIT_W-1:0] r_total;
    logic                         r_done;

    // result register
    logic                         r_out_valid;
    wrld_pkg::t_status            r_out_status;
    logic [wrld_pkg::OUT_W-1:0]   r_out_data;

    logic                         w_out_free;
    logic                         w_step;

    logic                         n_literal;
    logic                         n_await;
    logic [wrld_pkg::BYTE_W-1:0]  n_held;
    logic [wrld_pkg::LIMIT_W-1:0] n_total;
    logic                         n_done;
    logic                         n_emit;
    wrld_pkg::t_status            n_status;
    logic [wrld_pkg::OUT_W-1:0]   n_data;

    logic                         c_literal;
    logic                         c_await;
    logic [wrld_pkg::BYTE_W-1:0]  c_held;
    logic [wrld_pkg::LIMIT_W-1:0] c_total;
    logic                         c_done;
    logic [wrld_pkg::BYTE_W-1:0]  c_byte;
    logic [wrld_pkg::REPS_W-1:0]  c_reps;
    logic [wrld_pkg::LIMIT_W:0]   c_sum;
    logic                         c_ovf;
    logic                         c_data_byte;

    assign w_out_free = !r_out_valid || m_tready;
    assign w_step     = r_in_valid && w_out_free;
    assign s_tready   = !r_in_valid || w_out_free;

    assign m_tvalid = r_out_valid;
    assign m_tuser  = r_out_status;
    assign m_tdata  = r_out_data;

    always_comb begin
        // start of stream clears everything before the byte is decoded
        c_literal = r_in_sos ? 1'b0 : r_literal;
        c_await   = r_in_sos ? 1'b0 : r_await;
        c_held    = r_in_sos ? '0   : r_held;
        c_total   = r_in_sos ? '0   : r_total;
        c_done    = r_in_sos ? 1'b0 : r_done;

        c_byte = c_await ? c_held : r_in_byte;
        c_reps = c_await ? ({1'b0, r_in_byte} + 9'd1) : 9'd1;
        c_sum  = {1'b0, c_total} + {11'd0, c_reps, 2'b00};
        c_ovf  = c_sum >= {1'b0, w_cfg.max_length};

        n_literal = c_literal;
        n_await   = c_await;
        n_held    = c_held;
        n_total   = c_total;
        n_done    = c_done;
        n_emit    = 1'b0;
        n_status  = wrld_pkg::ST_RUN;
        n_data    = '0;
        c_data_byte = 1'b0;

        if (!c_done) begin
            if (c_await) begin
                n_await     = 1'b0;
                c_data_byte = 1'b1;
            end else if (r_in_byte == w_cfg.end_code) begin
                n_done   = 1'b1;
                n_emit   = 1'b1;
                n_status = wrld_pkg::ST_END;
                n_data[36:17] = c_total[wrld_pkg::LIMIT_W-1] ? wrld_pkg::TOTAL_SAT
                                : c_total[wrld_pkg::TOTAL_W-1:0];
            end else if (r_in_byte == w_cfg.toggle_code) begin
                n_literal = !c_literal;
            end else if (c_literal) begin
                c_data_byte = 1'b1;
            end else begin
                n_held  = r_in_byte;
                n_await = 1'b1;
            end

            if (c_data_byte) begin
                n_emit = 1'b1;
                if (c_ovf) begin
                    n_done   = 1'b1;
                    n_status = wrld_pkg::ST_OVERFLOW;
                end else begin
                    n_total       = c_sum[wrld_pkg::LIMIT_W-1:0];
                    n_data[7:0]   = c_byte;
                    n_data[16:8]  = c_reps;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_literal   <= 1'b0;
            r_await     <= 1'b0;
            r_held      <= '0;
            r_total     <= '0;
            r_done      <= 1'b0;
        end else begin
            if (s_tready) begin
                r_in_valid <= s_tvalid;
            end
            if (w_step) begin
                r_literal <= n_literal;
                r_await   <= n_await;
                r_held    <= n_held;
                r_total   <= n_total;
                r_done    <= n_done;
            end
            if (w_out_free) begin
                r_out_valid <= w_step && n_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tready) begin
            r_in_byte <= s_tdata;
            r_in_sos  <= s_tuser;
        end
        if (w_step && n_emit) begin
            r_out_status <= n_status;
            r_out_data   <= n_data;
        end
    end

`ifndef NO_ASSERTIONS
    a_ovf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == wrld_pkg::ST_OVERFLOW) |-> (r_out_data == '0))
        else $error("overflow result carries payload");

    a_done_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && n_emit && n_status != wrld_pkg::ST_RUN) |=> r_done)
        else $error("stream not closed after end or overflow");

    a_await_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_await |-> !r_literal)
        else $error("count pending in literal mode");
`endif

endmodule

`default_nettype wire

/* design/wrld_regs.sv */
`default_nettype none

module wrld_regs (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire  [wrld_pkg::ADDR_W-1:0]      paddr,
    input  wire  [wrld_pkg::DATA_W-1:0]      pwdata,
    output logic [wrld_pkg::DATA_W-1:0]      prdata,
    output logic                             pready,
    output wrld_pkg::t_cfg                   o_cfg
);

    wrld_pkg::t_cfg   r_cfg;
    wrld_pkg::t_reg_idx w_idx;
    logic             w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = wrld_pkg::t_reg_idx'(paddr[3:2]);
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.end_code    <= wrld_pkg::END_CODE_RST;
            r_cfg.toggle_code <= wrld_pkg::TOGGLE_CODE_RST;
            r_cfg.max_length  <= wrld_pkg::MAX_LENGTH_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                wrld_pkg::REG_END_CODE: begin
                    r_cfg.end_code <= pwdata[wrld_pkg::BYTE_W-1:0];
                end
                wrld_pkg::REG_TOGGLE_CODE: begin
                    r_cfg.toggle_code <= pwdata[wrld_pkg::BYTE_W-1:0];
                end
                wrld_pkg::REG_MAX_LENGTH: begin
                    r_cfg.max_length <= pwdata[wrld_pkg::LIMIT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (w_idx)
            wrld_pkg::REG_END_CODE: begin
                prdata[wrld_pkg::BYTE_W-1:0] = r_cfg.end_code;
            end
            wrld_pkg::REG_TOGGLE_CODE: begin
                prdata[wrld_pkg::BYTE_W-1:0] = r_cfg.toggle_code;
            end
            wrld_pkg::REG_MAX_LENGTH: begin
                prdata[wrld_pkg::LIMIT_W-1:0] = r_cfg.max_length;
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

/* bench/tb.sv */
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [2:0]                   pad;
        logic [wrld_pkg::TOTAL_W-1:0] total;
        logic [wrld_pkg::REPS_W-1:0]  reps;
        logic [wrld_pkg::PHASE_W-1:0] ph3;
        logic [wrld_pkg::PHASE_W-1:0] ph2;
        logic [wrld_pkg::PHASE_W-1:0] ph1;
        logic [wrld_pkg::PHASE_W-1:0] ph0;
    } t_run_word;

    typedef struct packed {
        wrld_pkg::t_status st;
        t_run_word         w;
    } t_run_due;

    logic                          i_clk    = 1'b0;
    logic                          i_rst_n  = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [7:0]                    s_tdata  = '0;  // [7:0] byte_in
    logic                          s_tuser  = 1'b0;  // [0] start_of_stream
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    // [1:0] phase_0, [3:2] phase_1, [5:4] phase_2, [7:6] phase_3,
    // [16:8] repeat_count, [36:17] total_values, [39:37] zero
    logic [wrld_pkg::OUT_W-1:0]    m_tdata;
    logic [wrld_pkg::STATUS_W-1:0] m_tuser;  // [1:0] status
    logic                          psel     = 1'b0;
    logic                          penable  = 1'b0;
    logic                          pwrite   = 1'b0;
    logic [wrld_pkg::ADDR_W-1:0]   paddr    = '0;
    logic [wrld_pkg::DATA_W-1:0]   pwdata   = '0;
    logic [wrld_pkg::DATA_W-1:0]   prdata;
    logic                          pready;

    // decoder state and register copies
    logic [wrld_pkg::BYTE_W-1:0]  cfg_end    = wrld_pkg::END_CODE_RST;
    logic [wrld_pkg::BYTE_W-1:0]  cfg_toggle = wrld_pkg::TOGGLE_CODE_RST;
    logic [wrld_pkg::LIMIT_W-1:0] cfg_limit  = wrld_pkg::MAX_LENGTH_RST;
    logic                         dec_literal = 1'b0;
    logic                         dec_await   = 1'b0;
    logic [wrld_pkg::BYTE_W-1:0]  dec_held    = '0;
    logic [wrld_pkg::LIMIT_W-1:0] dec_total   = '0;
    logic                         dec_done    = 1'b0;

    t_run_due    runs_due[$];
    int unsigned src_idle   = 0;
    int unsigned sink_idle  = 0;
    int unsigned hold_off   = 0;
    int unsigned live_items = 0;
    int unsigned mismatches = 0;
    int unsigned cycles;

    waveform_run_length_decoder u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #10 i_clk = ~i_clk;

    function automatic void emit_copy(input logic [wrld_pkg::BYTE_W-1:0] b,
                                      input logic [wrld_pkg::REPS_W-1:0] reps);
        logic [31:0] sum;
        t_run_due    r;
        sum = 32'(dec_total) + 32'(reps) * 32'd4;
        r = '0;
        if (sum >= 32'(cfg_limit)) begin
            dec_done = 1'b1;
            r.st = wrld_pkg::ST_OVERFLOW;
        end else begin
            dec_total = sum[wrld_pkg::LIMIT_W-1:0];
            r.st = wrld_pkg::ST_RUN;
            r.w.ph0 = b[1:0];
            r.w.ph1 = b[3:2];
            r.w.ph2 = b[5:4];
            r.w.ph3 = b[7:6];
            r.w.reps = reps;
        end
        runs_due.push_back(r);
    endfunction

    function automatic void decode_step(input logic [wrld_pkg::BYTE_W-1:0] b, input logic sos);
        t_run_due r;
        if (sos) begin
            dec_literal = 1'b0;
            dec_await   = 1'b0;
            dec_held    = '0;
            dec_total   = '0;
            dec_done    = 1'b0;
        end
        if (dec_done)
            return;
        live_items++;
        if (dec_await) begin
            dec_await = 1'b0;
            emit_copy(dec_held, {1'b0, b} + 9'd1);
        end else if (b == cfg_end) begin
            dec_done = 1'b1;
            r = '0;
            r.st = wrld_pkg::ST_END;
            r.w.total = (dec_total > wrld_pkg::LIMIT_W'(wrld_pkg::TOTAL_SAT))
                        ? wrld_pkg::TOTAL_SAT : dec_total[wrld_pkg::TOTAL_W-1:0];
            runs_due.push_back(r);
        end else if (b == cfg_toggle) begin
            dec_literal = ~dec_literal;
        end else if (dec_literal) begin
            emit_copy(b, 9'd1);
        end else begin
            dec_held  = b;
            dec_await = 1'b1;
        end
    endfunction

    function automatic logic [wrld_pkg::BYTE_W-1:0] plain_byte();
        logic [wrld_pkg::BYTE_W-1:0] b;
        do
            b = 8'($urandom_range(255));
        while (b == cfg_end || b == cfg_toggle);
        return b;
    endfunction

    task automatic note_mismatch(input string what, input t_run_due want,
                                 input logic [wrld_pkg::STATUS_W-1:0] st,
                                 input t_run_word got);
        mismatches++;
        if (mismatches <= 10)
            $display({"%s: exp st %0d ph %0d/%0d/%0d/%0d reps %0d total %0d, ",
                      "got st %0d ph %0d/%0d/%0d/%0d reps %0d total %0d"},
                     what, want.st, want.w.ph0, want.w.ph1, want.w.ph2, want.w.ph3,
                     want.w.reps, want.w.total, st, got.ph0, got.ph1, got.ph2, got.ph3,
                     got.reps, got.total);
    endtask

    // result checker; values are stable at the falling edge before the transfer
    always @(negedge i_clk) begin : result_check
        t_run_word got;
        t_run_due  want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got = m_tdata;
            if (runs_due.size() == 0) begin
                want = '0;
                note_mismatch("unexpected transfer", want, m_tuser, got);
            end else begin
                want = runs_due.pop_front();
                if (m_tuser !== want.st || got.ph0 !== want.w.ph0 || got.ph1 !== want.w.ph1 ||
                    got.ph2 !== want.w.ph2 || got.ph3 !== want.w.ph3 ||
                    got.reps !== want.w.reps || got.total !== want.w.total)
                    note_mismatch("mismatch", want, m_tuser, got);
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_off > 0) begin
            m_tready <= 1'b0;
            hold_off = hold_off - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= sink_idle);
        end
    end

    initial begin
        for (cycles = 0; cycles < CYCLE_LIMIT; cycles++)
            @(posedge i_clk);
        $display("status: fail");
        $finish;
    end

    task automatic send_byte(input logic [wrld_pkg::BYTE_W-1:0] b, input logic sos);
        while ($urandom_range(99) < src_idle) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= sos;
        @(negedge i_clk);
        while (!s_tready)
            @(negedge i_clk);
        decode_step(b, sos);
        @(posedge i_clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (runs_due.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_write(input wrld_pkg::t_reg_idx idx,
                             input logic [wrld_pkg::DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        while (!pready)
            @(negedge i_clk);
        @(posedge i_clk);
        case (idx)
            wrld_pkg::REG_END_CODE:    cfg_end    = val[wrld_pkg::BYTE_W-1:0];
            wrld_pkg::REG_TOGGLE_CODE: cfg_toggle = val[wrld_pkg::BYTE_W-1:0];
            wrld_pkg::REG_MAX_LENGTH:  cfg_limit  = val[wrld_pkg::LIMIT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic [wrld_pkg::BYTE_W-1:0] end_c,
                             input logic [wrld_pkg::BYTE_W-1:0] tog_c,
                             input logic [wrld_pkg::LIMIT_W-1:0] limit);
        apb_write(wrld_pkg::REG_END_CODE, 32'(end_c));
        apb_write(wrld_pkg::REG_TOGGLE_CODE, 32'(tog_c));
        apb_write(wrld_pkg::REG_MAX_LENGTH, 32'(limit));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // mostly well-formed stream: runs, literals, toggles, an end; some noise
    task automatic send_stream(input int unsigned len);
        logic                        lit;
        logic                        first;
        logic                        sos;
        logic [wrld_pkg::BYTE_W-1:0] cnt;
        int unsigned                 n;
        int unsigned                 pick;
        lit   = 1'b0;
        first = 1'b1;
        for (n = 0; n < len; n++) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                send_byte(cfg_toggle, first);
                lit = ~lit;
            end else if (pick < 11) begin
                send_byte(cfg_end, first);
                if ($urandom_range(3) == 0)
                    send_byte(8'($urandom_range(255)), 1'b0);
                return;
            end else if (pick < 16) begin
                sos = ($urandom_range(3) == 0);
                send_byte(8'($urandom_range(255)), sos | first);
                if (sos | first)
                    lit = 1'b0;
            end else if (lit) begin
                send_byte(plain_byte(), first);
            end else begin
                send_byte(plain_byte(), first);
                case ($urandom_range(15))
                    0:       cnt = cfg_end;
                    1:       cnt = cfg_toggle;
                    default: cnt = 8'($urandom_range(255));
                endcase
                send_byte(cnt, 1'b0);
                n++;
            end
            first = 1'b0;
        end
    endtask

    task automatic run_block(input int unsigned kind, input int unsigned target);
        logic [wrld_pkg::BYTE_W-1:0] code;
        code = 8'($urandom_range(255));
        case (kind)
            0: configure(8'hFF, 8'h00, wrld_pkg::MAX_LENGTH_RST);
            1: configure(8'h00, 8'hFF, 21'($urandom_range(1, 64)));
            2: configure(8'($urandom_range(255)), 8'($urandom_range(255)),
                         21'($urandom_range(1, 30000)));
            default: configure(code, code, 21'($urandom_range(1, 1048576)));
        endcase
        live_items = 0;
        while (live_items < target)
            send_stream($urandom_range(4, 60));
        drain();
    endtask

    task automatic test_default_codes();
        send_byte(8'h1B, 1'b1);
        send_byte(8'hFF, 1'b0);  // count equal to end code
        send_byte(8'hE4, 1'b0);
        send_byte(8'hFC, 1'b0);  // count equal to toggle code
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFC, 1'b0);
        send_byte(8'hAB, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'hFC, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h12, 1'b0);  // ignored, stream done
        send_byte(8'hFF, 1'b1);
        send_byte(8'h80, 1'b1);
        send_byte(8'h01, 1'b1);  // restart while a count is pending
        send_byte(8'h02, 1'b0);
        send_byte(8'hFF, 1'b0);
        drain();
    endtask

    task automatic test_code_extremes();
        configure(8'h00, 8'hFF, 21'd8);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hAA, 1'b0);
        send_byte(8'hAA, 1'b0);  // total reaches the limit
        send_byte(8'h33, 1'b0);
        send_byte(8'h00, 1'b1);
        drain();
        configure(8'h5A, 8'h5A, 21'd1);
        send_byte(8'h5A, 1'b1);  // equal codes: end wins
        send_byte(8'h11, 1'b1);
        send_byte(8'h00, 1'b0);
        drain();
        configure(8'h5A, 8'hFC, 21'd0);
        send_byte(8'h01, 1'b1);
        send_byte(8'h00, 1'b0);
        drain();
    endtask

    task automatic test_random_phase(input int unsigned src, input int unsigned sink);
        int unsigned k;
        src_idle  = src;
        sink_idle = sink;
        for (k = 0; k < 4; k++)
            run_block(k, 115);
    endtask

    task automatic test_backpressure();
        int unsigned k;
        configure(8'hFF, 8'hFC, wrld_pkg::MAX_LENGTH_RST);
        hold_off = 300;
        send_byte(8'hFC, 1'b1);
        for (k = 0; k < 40; k++)
            send_byte(plain_byte(), 1'b0);
        drain();
    endtask

    initial begin
        src_idle  = 24;
        sink_idle = 62;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_default_codes();
        test_code_extremes();
        test_random_phase(24, 62);
        test_random_phase(62, 24);
        test_random_phase(0, 0);
        test_backpressure();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && runs_due.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
